[hdl/nsv_pkg.sv]
`timescale 1ns / 1ps

package nsv_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [2:0] TALKER_LEN = 3'd6;
	localparam logic [2:0] TAIL_LEN   = 3'd3;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_EMPTY       = 3'd1;
	localparam logic [2:0] ST_NO_START    = 3'd2;
	localparam logic [2:0] ST_MISSING_SUM = 3'd3;
	localparam logic [2:0] ST_BAD_SUM     = 3'd4;
	localparam logic [2:0] ST_BAD_TALKER  = 3'd5;

	localparam logic [1:0] MODE_IGNORE   = 2'd0;
	localparam logic [1:0] MODE_IF_THERE = 2'd1;
	localparam logic [1:0] MODE_REQUIRE  = 2'd2;

	localparam logic IDX_CHECKSUM_MODE = 1'b0;
	localparam logic IDX_TALKER_CHECK  = 1'b1;

	typedef struct packed {
		logic [7:0] body_xor;
		logic       star_passed;
		logic [2:0] ffl;
		logic       comma_passed;
	} body_t;

	typedef struct packed {
		logic            seen_text;
		logic            start_ok;
		logic [2:0]      kept_len;
		logic [2:0][7:0] tail;
		logic [1:0]      fill;
		logic [2:0][7:0] run_chars;
		logic [3:0]      run_len;
		logic [7:0]      run_xor;
		body_t           body;
	} st_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] computed_sum;
		logic       sum_found;
	} res_t;

	function automatic logic is_space(logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_hex(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if (is_hex(c)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

	function automatic logic [2:0] ffl_add(logic [2:0] f, logic [3:0] n);
		logic [4:0] v;
		v = {2'b00, f} + {1'b0, n};
		return (v > 5'd7) ? 3'd7 : v[2:0];
	endfunction

	function automatic body_t body_take(body_t b, logic [7:0] x);
		body_t r;
		logic  first;
		r = b;
		first = (b.ffl == 3'd0) && !b.comma_passed;
		if (x == CH_COMMA) begin
			r.comma_passed = 1'b1;
		end else if (!b.comma_passed) begin
			r.ffl = ffl_add(b.ffl, 4'd1);
		end
		if (!first) begin
			if (x == CH_STAR) begin
				r.star_passed = 1'b1;
			end else if (!b.star_passed) begin
				r.body_xor = b.body_xor ^ x;
			end
		end
		return r;
	endfunction

	function automatic st_t commit(st_t s, logic [7:0] x);
		st_t r;
		r = s;
		if (s.kept_len < 3'd4) begin
			r.kept_len = s.kept_len + 3'd1;
		end
		unique case (s.fill)
			2'd0: begin
				r.tail[0] = x;
				r.fill = 2'd1;
			end
			2'd1: begin
				r.tail[1] = x;
				r.fill = 2'd2;
			end
			2'd2: begin
				r.tail[2] = x;
				r.fill = 2'd3;
			end
			default: begin
				r.body = body_take(s.body, s.tail[0]);
				r.tail[0] = s.tail[1];
				r.tail[1] = s.tail[2];
				r.tail[2] = x;
			end
		endcase
		return r;
	endfunction

	function automatic st_t release_run(st_t s);
		st_t        r;
		logic [7:0] head_xor;
		r = s;
		head_xor = s.run_xor ^ s.run_chars[0] ^ s.run_chars[1] ^ s.run_chars[2];
		if (s.run_len != 4'd0) begin
			if (s.run_len <= 4'd3) begin
				for (int i = 0; i < 3; i++) begin
					if (4'(i) + s.run_len >= 4'd3) begin
						r = commit(r, s.run_chars[i]);
					end
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < s.fill) begin
						r.body = body_take(r.body, s.tail[i]);
					end
				end
				if (!r.body.comma_passed) begin
					r.body.ffl = ffl_add(r.body.ffl, s.run_len - 4'd3);
				end
				if (!r.body.star_passed) begin
					r.body.body_xor = r.body.body_xor ^ head_xor;
				end
				r.tail = s.run_chars;
				r.fill = 2'd3;
				r.kept_len = 3'd4;
			end
			r.run_len = 4'd0;
			r.run_xor = 8'd0;
			r.run_chars = '0;
		end
		return r;
	endfunction

endpackage

[hdl/nsv_char_if.sv]
`timescale 1ns / 1ps

interface nsv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_sentence;

	modport source (output valid, output char_in, output end_of_sentence, input ready);
	modport sink (input valid, input char_in, input end_of_sentence, output ready);
endinterface

[hdl/nsv_result_if.sv]
`timescale 1ns / 1ps

interface nsv_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] computed_sum;
	logic       sum_found;

	modport source (output valid, output status, output computed_sum, output sum_found,
		input ready);
	modport sink (input valid, input status, input computed_sum, input sum_found,
		output ready);
endinterface

[hdl/nsv_step.sv]
`timescale 1ns / 1ps

module nsv_step (
	input  nsv_pkg::st_t       cur,
	input  logic [7:0]         char_in,
	input  logic               end_of_sentence,
	input  logic [1:0]         checksum_mode,
	input  logic               check_talker_length,
	output nsv_pkg::st_t       nxt,
	output nsv_pkg::res_t      res
);
	import nsv_pkg::*;

	st_t        s;
	body_t      b;
	logic       found;
	logic       check;
	logic [7:0] given;

	always_comb begin
		s = cur;
		if (is_space(char_in)) begin
			if (cur.seen_text) begin
				s.run_chars[0] = cur.run_chars[1];
				s.run_chars[1] = cur.run_chars[2];
				s.run_chars[2] = char_in;
				s.run_xor = cur.run_xor ^ char_in;
				if (cur.run_len < 4'd15) begin
					s.run_len = cur.run_len + 4'd1;
				end
			end
		end else if (!cur.seen_text) begin
			s.seen_text = 1'b1;
			s.start_ok = (char_in == CH_DOLLAR) || (char_in == CH_BANG);
			s = commit(s, char_in);
		end else begin
			s = release_run(s);
			s = commit(s, char_in);
		end

		b = s.body;
		found = 1'b0;
		given = 8'd0;
		check = (checksum_mode == MODE_IF_THERE) || (checksum_mode == MODE_REQUIRE);
		if (s.kept_len > TAIL_LEN && s.fill == 2'd3 && s.tail[0] == CH_STAR) begin
			found = is_hex(s.tail[1]) && is_hex(s.tail[2]);
			given = {hex_val(s.tail[1]), hex_val(s.tail[2])};
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < s.fill) begin
					b = body_take(b, s.tail[i]);
				end
			end
		end

		res.computed_sum = 8'd0;
		res.sum_found = 1'b0;
		if (!s.seen_text) begin
			res.status = ST_EMPTY;
		end else if (!s.start_ok) begin
			res.status = ST_NO_START;
		end else begin
			res.computed_sum = b.body_xor;
			res.sum_found = found;
			if (checksum_mode == MODE_REQUIRE && !found) begin
				res.status = ST_MISSING_SUM;
			end else if (found && check && b.body_xor != given) begin
				res.status = ST_BAD_SUM;
			end else if (check_talker_length && b.ffl != TALKER_LEN) begin
				res.status = ST_BAD_TALKER;
			end else begin
				res.status = ST_OK;
			end
		end

		nxt = end_of_sentence ? '0 : s;
	end
endmodule

[hdl/nmea_sentence_validator_unit.sv]
`timescale 1ns / 1ps
// The result of a sentence is registered when its final byte leaves the input register.
// Throughput: one byte per cycle while no final byte is stalled; the per-byte state update
// is one pass of logic between the input register and the state and result registers.
// A waiting result stalls only a final byte; other bytes keep flowing.
// Reset clears all sentence state and sets checksum_mode to 1 and check_talker_length to 1.

module nmea_sentence_validator_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	nsv_char_if.sink             chars,
	nsv_result_if.source         results,
	input  logic                 wr_en,
	input  logic                 wr_index,
	input  logic [1:0]           wr_data
);
	import nsv_pkg::*;

	logic       s1_valid_q;
	logic [7:0] char_s1;
	logic       eos_s1;
	logic [1:0] mode_q;
	logic       talker_q;
	st_t        state_q;
	st_t        state_nxt;
	res_t       res_nxt;
	res_t       res_q;
	logic       res_valid_q;
	logic       proc;

	assign proc = s1_valid_q && (!eos_s1 || !res_valid_q || results.ready);
	assign chars.ready = !s1_valid_q || proc;

	nsv_step u_step (
		.cur                 (state_q),
		.char_in             (char_s1),
		.end_of_sentence     (eos_s1),
		.checksum_mode       (mode_q),
		.check_talker_length (talker_q),
		.nxt                 (state_nxt),
		.res                 (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IF_THERE;
			talker_q <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				IDX_CHECKSUM_MODE: mode_q <= wr_data;
				IDX_TALKER_CHECK:  talker_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			s1_valid_q <= 1'b1;
		end else if (proc) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_in;
			eos_s1 <= chars.end_of_sentence;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (proc) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc && eos_s1) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && eos_s1) begin
			res_q <= res_nxt;
		end
	end

	assign results.valid = res_valid_q;
	assign results.status = res_q.status;
	assign results.computed_sum = res_q.computed_sum;
	assign results.sum_found = res_q.sum_found;

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		proc && eos_s1 |=> !state_q.seen_text && state_q.fill == 2'd0)
		else $error("Sentence state was not cleared after the final byte.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(proc && eos_s1))
		else $error("A result appeared without a final byte.");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.status == ST_EMPTY || res_q.status == ST_NO_START) |->
		res_q.computed_sum == 8'd0 && !res_q.sum_found)
		else $error("A rejected sentence reported a checksum.");

	a_run_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.run_len == 4'd0 |-> state_q.run_xor == 8'd0)
		else $error("Whitespace run XOR is set with an empty run.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !results.ready |-> !(proc && eos_s1))
		else $error("A waiting result was overwritten.");
endmodule
